[design/ffmc_pkg.sv]
// package for the filament feed mode controller: codes, types and widths
package ffmc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DistW = 21;
  localparam int unsigned SpeedW = 20;
  localparam int unsigned MagW = 31;  // |distance|*1000 fits in 31 bits
  localparam int unsigned QW = 31;
  localparam logic [9:0] Thousand = 10'd1000;
  localparam logic [TimeW-1:0] ShortPressLimit = 32'd150;
  localparam logic [TimeW-1:0] QuickGapMin = 32'd50;
  localparam logic [TimeW-1:0] QuickGapMax = 32'd500;

  typedef enum logic [3:0] {
    ACT_NONE = 4'd0, ACT_PUSH = 4'd1, ACT_RETRACT = 4'd2, ACT_HOLD = 4'd3,
    ACT_REGULAR = 4'd4, ACT_OFF = 4'd5, ACT_QUERY = 4'd6, ACT_MOVE = 4'd7,
    ACT_HOLD_LIMIT_ON = 4'd8, ACT_HOLD_LIMIT_OFF = 4'd9
  } action_t;

  typedef enum logic [2:0] {
    MODE_REGULAR = 3'd0, MODE_CONTINUOUS = 3'd1, MODE_MOVE = 3'd2,
    MODE_HOLD = 3'd3, MODE_MANUAL = 3'd4, MODE_OFF = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    MOT_OFF = 2'd0, MOT_PUSH = 2'd1, MOT_RETRACT = 2'd2, MOT_HOLD = 2'd3
  } motor_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIVIDE, ST_APPLY, ST_OUT
  } state_t;

  localparam logic [1:0] RegMoveTimeout = 2'd0;
  localparam logic [1:0] RegHoldTimeout = 2'd1;
  localparam logic [1:0] RegMultiPress = 2'd2;
  localparam logic [1:0] RegFeedSpeed = 2'd3;

endpackage

[design/filament_feed_mode_controller.sv]
// top level of the filament feed mode controller
// One input word is one millisecond tick. The block latches it, then for a move
// command runs a restoring divider (a load cycle, one quotient bit per cycle for all
// 31 quotient bits, then a finishing cycle) to get |distance|*1000/feed_speed, then
// applies command, button, mode and hold rules in the apply state and presents the
// result word. The input is not ready from acceptance until the result word has
// been taken. Configuration goes through the APB port: move_timeout_ms at 0x0,
// hold_timeout_ms at 0x4, multi_press_needed at 0x8, feed_speed at 0xC.
module filament_feed_mode_controller
  import ffmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // action[3:0], time_ms[35:4], fil_switch[36], sensor_low[37],
  // sensor_mid[38], sensor_high[39], button_forward[40], button_backward[41],
  // move_distance[62:42], zero fill [63]
  input  logic [63:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // motor_command[1:0], mode_now[4:2], timed_out_flag[5], presence_signal[6],
  // filament_changed[7], mode_changed[8], motor_changed[9], timeout_changed[10]
  output logic [15:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [31:0]       move_timeout_ms, hold_timeout_ms;
  logic [7:0]        multi_press_needed;
  logic [SpeedW-1:0] feed_speed;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      move_timeout_ms <= '0;
      hold_timeout_ms <= '0;
      multi_press_needed <= 8'd3;
      feed_speed <= 20'd10000;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        RegMoveTimeout: move_timeout_ms <= pwdata;
        RegHoldTimeout: hold_timeout_ms <= pwdata;
        RegMultiPress:  multi_press_needed <= pwdata[7:0];
        RegFeedSpeed:   feed_speed <= pwdata[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        RegMoveTimeout: prdata = move_timeout_ms;
        RegHoldTimeout: prdata = hold_timeout_ms;
        RegMultiPress:  prdata = {24'd0, multi_press_needed};
        RegFeedSpeed:   prdata = {12'd0, feed_speed};
        default:        prdata = '0;
      endcase
    end
  end

  // latched tick word
  logic [3:0]       act;
  logic [TimeW-1:0] now;
  logic             fil, s_low, s_mid, s_high, b_fwd, b_back;
  logic [DistW-1:0] move_dist;

  // sequencer
  state_t state, state_next;
  logic [5:0] bit_cnt;
  logic [QW-1:0] quot;
  logic [SpeedW:0] rem;
  logic [MagW-1:0] dividend;

  // magnitude of the distance, times 1000
  logic             neg;
  logic [DistW-1:0] mag;
  logic [MagW-1:0]  mag_k;
  assign neg   = move_dist[DistW-1];
  assign mag   = neg ? (~move_dist + 1'b1) : move_dist;
  assign mag_k = MagW'(mag) * MagW'(Thousand);

  logic move_go;
  assign move_go = (act == ACT_MOVE) && (mag != '0) && (feed_speed != '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_DIVIDE;
      ST_DIVIDE: if (!move_go || bit_cnt == 6'd0) state_next = ST_APPLY;
      ST_APPLY:  state_next = ST_OUT;
      ST_OUT:    if (m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_OUT);
  end

  // restoring divider step
  logic [SpeedW:0] rem_sh;
  logic [SpeedW+1:0] rem_try;
  assign rem_sh  = {rem[SpeedW-1:0], dividend[MagW-1]};
  assign rem_try = {1'b0, rem_sh} - {2'b00, feed_speed};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == ST_IDLE && s_tvalid) begin
      act    <= s_tdata[3:0];
      now    <= s_tdata[35:4];
      fil    <= s_tdata[36];
      s_low  <= s_tdata[37];
      s_mid  <= s_tdata[38];
      s_high <= s_tdata[39];
      b_fwd  <= s_tdata[40];
      b_back <= s_tdata[41];
      move_dist <= s_tdata[62:42];
      bit_cnt <= 6'(MagW + 1);
      rem <= '0;
      quot <= '0;
      dividend <= '0;
    end else if (state == ST_DIVIDE) begin
      if (bit_cnt == 6'(MagW + 1)) begin
        dividend <= mag_k;
        bit_cnt <= bit_cnt - 1'b1;
      end else if (bit_cnt != 6'd0) begin
        if (!rem_try[SpeedW+1]) begin
          rem <= rem_try[SpeedW:0];
          quot <= {quot[QW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quot <= {quot[QW-2:0], 1'b0};
        end
        dividend <= {dividend[MagW-2:0], 1'b0};
        bit_cnt <= bit_cnt - 1'b1;
      end
    end
  end

  // control state
  logic started, timed_out_reg, hold_limit_on, presence_latch;
  mode_t mode_reg;
  motor_t motor_reg;
  logic [TimeW-1:0] sensor_move_start, continuous_start, hold_start, move_end;
  logic [1:0] button_down;
  logic [TimeW-1:0] press_start [2];
  logic [TimeW-1:0] last_release [2];
  logic [7:0] press_count [2];
  logic rep_fil, rep_to;
  mode_t rep_mode;
  motor_t rep_motor;
  logic ch_fil, ch_mode, ch_motor, ch_to;

  logic started_next, timed_out_next, hold_limit_next, presence_next;
  mode_t mode_next;
  motor_t motor_next;
  logic [TimeW-1:0] sensor_start_next, cont_start_next, hold_start_next, move_end_next;
  logic [1:0] button_down_next;
  logic [TimeW-1:0] press_start_next [2];
  logic [TimeW-1:0] last_release_next [2];
  logic [7:0] press_count_next [2];
  logic rep_fil_next, rep_to_next;
  mode_t rep_mode_next;
  motor_t rep_motor_next;
  logic ch_fil_next, ch_mode_next, ch_motor_next, ch_to_next;

  // tick rules, applied in order: start-up or command, buttons, mode rule, hold timeout, report
  always_comb begin
    logic pressed;
    logic moving;
    logic [TimeW-1:0] gap;
    logic [TimeW-1:0] held;
    motor_t dir;
    logic done;
    started_next = started;
    timed_out_next = timed_out_reg;
    hold_limit_next = hold_limit_on;
    presence_next = presence_latch;
    mode_next = mode_reg;
    motor_next = motor_reg;
    sensor_start_next = sensor_move_start;
    cont_start_next = continuous_start;
    hold_start_next = hold_start;
    move_end_next = move_end;
    button_down_next = button_down;
    press_start_next = press_start;
    last_release_next = last_release;
    press_count_next = press_count;
    rep_fil_next = rep_fil;
    rep_to_next = rep_to;
    rep_mode_next = rep_mode;
    rep_motor_next = rep_motor;
    ch_fil_next = 1'b0;
    ch_mode_next = 1'b0;
    ch_motor_next = 1'b0;
    ch_to_next = 1'b0;
    moving = 1'b0;
    pressed = 1'b0;
    gap = '0;
    held = '0;
    dir = MOT_OFF;
    done = 1'b0;

    if (!started) begin
      // start-up rule
      started_next = 1'b1;
      mode_next = fil ? MODE_REGULAR : MODE_OFF;
      motor_next = fil ? MOT_HOLD : MOT_OFF;
      if (fil) hold_start_next = now;
      rep_mode_next = mode_next;
      rep_motor_next = motor_next;
      presence_next = fil;
      if (fil != rep_fil) begin
        rep_fil_next = fil; ch_fil_next = 1'b1;
      end
      if (timed_out_next != rep_to) begin
        rep_to_next = timed_out_next; ch_to_next = 1'b1;
      end
    end else begin
      // command
      if (act >= 4'd1 && act <= 4'd9) begin
        case (act)
          ACT_PUSH, ACT_RETRACT: begin
            mode_next = MODE_CONTINUOUS;
            cont_start_next = now;
            motor_next = (act == ACT_PUSH) ? MOT_PUSH : MOT_RETRACT;
          end
          ACT_HOLD: begin
            hold_limit_next = 1'b0;
            mode_next = MODE_HOLD;
            if (motor_next != MOT_HOLD) hold_start_next = now;
            motor_next = MOT_HOLD;
          end
          ACT_REGULAR: begin
            mode_next = MODE_REGULAR;
            if (fil && motor_next != MOT_HOLD) hold_start_next = now;
            motor_next = fil ? MOT_HOLD : MOT_OFF;
          end
          ACT_OFF: begin
            mode_next = MODE_OFF;
            motor_next = MOT_OFF;
          end
          ACT_MOVE: begin
            if (move_go) begin
              move_end_next = now + TimeW'(quot);
              mode_next = MODE_MOVE;
              motor_next = neg ? MOT_RETRACT : MOT_PUSH;
            end
          end
          ACT_HOLD_LIMIT_ON: hold_limit_next = 1'b1;
          ACT_HOLD_LIMIT_OFF: hold_limit_next = 1'b0;
          default: ;
        endcase
        if (fil != rep_fil_next) begin
          rep_fil_next = fil; ch_fil_next = 1'b1;
        end
        if (mode_next != rep_mode_next) begin
          rep_mode_next = mode_next; ch_mode_next = 1'b1;
        end
        if (motor_next != rep_motor_next) begin
          rep_motor_next = motor_next; ch_motor_next = 1'b1;
        end
        if (timed_out_next != rep_to_next) begin
          rep_to_next = timed_out_next; ch_to_next = 1'b1;
        end
      end

      // buttons, forward then backward
      for (int b = 0; b < 2; b++) begin
        pressed = (b == 0) ? b_fwd : b_back;
        dir = (b == 0) ? MOT_PUSH : MOT_RETRACT;
        done = 1'b0;
        if (pressed) begin
          if (!button_down_next[b]) begin
            button_down_next[b] = 1'b1;
            press_start_next[b] = now;
            mode_next = MODE_MANUAL;
            motor_next = dir;
          end
        end else if (button_down_next[b]) begin
          button_down_next[b] = 1'b0;
          held = now - press_start_next[b];
          if (held <= ShortPressLimit) begin
            gap = now - last_release_next[b];
            if (gap >= QuickGapMin && gap <= QuickGapMax)
              press_count_next[b] = press_count_next[b] + 8'd1;
            else
              press_count_next[b] = 8'd1;
            last_release_next[b] = now;
            if (press_count_next[b] >= multi_press_needed) begin
              mode_next = MODE_CONTINUOUS;
              cont_start_next = now;
              motor_next = dir;
              press_count_next[b] = 8'd0;
              done = 1'b1;
            end else begin
              hold_limit_next = 1'b0;
            end
          end else begin
            press_count_next[b] = 8'd0;
          end
          if (!done) begin
            mode_next = fil ? MODE_REGULAR : MODE_OFF;
            if (fil && motor_next != MOT_HOLD) hold_start_next = now;
            motor_next = fil ? MOT_HOLD : MOT_OFF;
          end
        end
      end

      // mode rule
      case (mode_next)
        MODE_REGULAR: begin
          if (!fil) begin
            mode_next = MODE_OFF;
            motor_next = MOT_OFF;
          end else begin
            presence_next = 1'b1;
            if (s_low) begin
              motor_next = MOT_PUSH; sensor_start_next = now; moving = 1'b1;
            end else if (s_high) begin
              motor_next = MOT_RETRACT; sensor_start_next = now; moving = 1'b1;
            end else if (s_mid) begin
              if (motor_next != MOT_HOLD) hold_start_next = now;
              motor_next = MOT_HOLD;
            end
            if (motor_next == MOT_PUSH || motor_next == MOT_RETRACT) begin
              if (!moving && (now - sensor_start_next) > move_timeout_ms) begin
                timed_out_next = 1'b1;
                mode_next = MODE_HOLD;
                hold_start_next = now;
                motor_next = MOT_HOLD;
              end
            end else begin
              timed_out_next = 1'b0;
            end
          end
        end
        MODE_MOVE: begin
          if (now >= move_end_next) begin
            mode_next = fil ? MODE_REGULAR : MODE_OFF;
            if (fil && motor_next != MOT_HOLD) hold_start_next = now;
            motor_next = fil ? MOT_HOLD : MOT_OFF;
          end
        end
        MODE_CONTINUOUS: begin
          if (!fil) begin
            mode_next = MODE_OFF;
            motor_next = MOT_OFF;
          end else if (move_timeout_ms != '0 &&
                       (now - cont_start_next) > move_timeout_ms) begin
            mode_next = MODE_HOLD;
            if (motor_next != MOT_HOLD) hold_start_next = now;
            motor_next = MOT_HOLD;
          end
        end
        MODE_HOLD: begin
          if (motor_next != MOT_HOLD) hold_start_next = now;
          motor_next = MOT_HOLD;
        end
        MODE_OFF: motor_next = MOT_OFF;
        default: ;
      endcase

      // hold timeout
      if (hold_limit_next && motor_next == MOT_HOLD &&
          (now - hold_start_next) > hold_timeout_ms) begin
        mode_next = MODE_OFF;
        motor_next = MOT_OFF;
      end

      // end-of-tick report
      if (fil != rep_fil_next) begin
        rep_fil_next = fil; ch_fil_next = 1'b1;
      end
      if (mode_next != rep_mode_next) begin
        rep_mode_next = mode_next; ch_mode_next = 1'b1;
      end
      if (motor_next != rep_motor_next) begin
        rep_motor_next = motor_next; ch_motor_next = 1'b1;
      end
      if (timed_out_next != rep_to_next) begin
        rep_to_next = timed_out_next; ch_to_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      timed_out_reg <= 1'b0;
      hold_limit_on <= 1'b0;
      presence_latch <= 1'b0;
      mode_reg <= MODE_OFF;
      motor_reg <= MOT_OFF;
      sensor_move_start <= '0;
      continuous_start <= '0;
      hold_start <= '0;
      move_end <= '0;
      button_down <= '0;
      for (int b = 0; b < 2; b++) begin
        press_start[b] <= '0;
        last_release[b] <= '0;
        press_count[b] <= '0;
      end
      rep_fil <= 1'b0;
      rep_to <= 1'b0;
      rep_mode <= MODE_OFF;
      rep_motor <= MOT_OFF;
      ch_fil <= 1'b0;
      ch_mode <= 1'b0;
      ch_motor <= 1'b0;
      ch_to <= 1'b0;
    end else if (state == ST_APPLY) begin
      started <= started_next;
      timed_out_reg <= timed_out_next;
      hold_limit_on <= hold_limit_next;
      presence_latch <= presence_next;
      mode_reg <= mode_next;
      motor_reg <= motor_next;
      sensor_move_start <= sensor_start_next;
      continuous_start <= cont_start_next;
      hold_start <= hold_start_next;
      move_end <= move_end_next;
      button_down <= button_down_next;
      press_start <= press_start_next;
      last_release <= last_release_next;
      press_count <= press_count_next;
      rep_fil <= rep_fil_next;
      rep_to <= rep_to_next;
      rep_mode <= rep_mode_next;
      rep_motor <= rep_motor_next;
      ch_fil <= ch_fil_next;
      ch_mode <= ch_mode_next;
      ch_motor <= ch_motor_next;
      ch_to <= ch_to_next;
    end
  end

  assign m_tdata = {5'd0, ch_to, ch_motor, ch_mode, ch_fil, presence_latch,
                    timed_out_reg, mode_reg, motor_reg};

  // only one side of the stream is open at a time
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input and output open together");
  // the divider never runs past its bit count
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE && bit_cnt == 6'd0 |=> state == ST_APPLY)
    else $error("divider overran");
  // rule state moves only in the apply cycle
  assert property (@(posedge clk) disable iff (rst)
    state != ST_APPLY |=> $stable(mode_reg) && $stable(motor_reg))
    else $error("mode changed outside apply");
  // after a tick the reported copies track the live mode and motor
  assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> rep_mode == mode_reg && rep_motor == motor_reg)
    else $error("reported copies out of step");

endmodule
